### sv/pcc_pkg.sv
package pcc_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_ITEMS_DEF    = 1024;
    localparam int SAMPLE_WIDTH_DEF = 16;

    // Fixed field widths of the channel words
    localparam int SAMPLE_PORT_W = 16;
    localparam int COUNT_PORT_W  = 11;
    localparam int Q_W           = 16;

    // Quotient of num^2 * 2^30 / den lies in [0, 2^30]
    localparam int QUO_W     = 31;
    localparam int SQRT_BITS = 16;
    localparam int STEP_W    = 5;

    localparam logic [Q_W-1:0] Q_POS_MAX = 16'h7FFF;

    // Microcode for the shared shift-add unit
    localparam int NUM_UOPS = 8;
    localparam int UOP_W    = 3;

    typedef struct packed {
        logic signed [SAMPLE_PORT_W-1:0] sample_x;
        logic signed [SAMPLE_PORT_W-1:0] sample_y;
        logic                            last_pair;
    } pair_t;

    typedef struct packed {
        logic signed [Q_W-1:0]          corr_q15;
        logic                           degenerate;
        logic                           overflow;
        logic        [COUNT_PORT_W-1:0] pair_count;
    } result_t;

    typedef enum logic [2:0] {
        S_ACC,
        S_LOAD,
        S_MUL,
        S_DIV,
        S_SQRT,
        S_DONE
    } state_t;

    typedef enum logic [3:0] {
        SRC_N,
        SRC_SX,
        SRC_SY,
        SRC_SXY,
        SRC_SXX,
        SRC_SYY,
        SRC_VX,
        SRC_VY,
        SRC_NUM
    } src_t;

    typedef enum logic [2:0] {
        DST_NONE,
        DST_NUM,
        DST_VX,
        DST_VY,
        DST_DEN
    } dst_t;

    typedef struct packed {
        src_t src_a;
        src_t src_b;
        logic sub;     // subtract product from accumulator
        logic clr;     // clear accumulator before this product
        dst_t dst;
    } uop_t;

    // num = n*Sxy - Sx*Sy, vx, vy, den = vx*vy, then num^2 left in the accumulator
    function automatic uop_t uop_at(input logic [UOP_W-1:0] idx);
        uop_t u;
        case (idx)
            3'd0:    u = '{SRC_N,   SRC_SXY, 1'b0, 1'b1, DST_NONE};
            3'd1:    u = '{SRC_SX,  SRC_SY,  1'b1, 1'b0, DST_NUM};
            3'd2:    u = '{SRC_N,   SRC_SXX, 1'b0, 1'b1, DST_NONE};
            3'd3:    u = '{SRC_SX,  SRC_SX,  1'b1, 1'b0, DST_VX};
            3'd4:    u = '{SRC_N,   SRC_SYY, 1'b0, 1'b1, DST_NONE};
            3'd5:    u = '{SRC_SY,  SRC_SY,  1'b1, 1'b0, DST_VY};
            3'd6:    u = '{SRC_VX,  SRC_VY,  1'b0, 1'b1, DST_DEN};
            3'd7:    u = '{SRC_NUM, SRC_NUM, 1'b0, 1'b1, DST_NONE};
            default: u = '{SRC_N,   SRC_SXY, 1'b0, 1'b1, DST_NONE};
        endcase
        return u;
    endfunction

endpackage

### sv/pearson_correlation_core.sv
// Pearson correlation core. Each accepted word carries one (x, y) sample pair;
// pairs are summed at one per cycle into Sx, Sy, Sxy, Sxx, Syy and a count
// (pairs past MAX_ITEMS are dropped and flag overflow). The word with
// last_pair set closes the vector: the core stalls its input and runs one
// shared shift-add/subtract unit through eight multiply passes (num, vx, vy,
// den = vx*vy, num^2), each loading its operands and then shifting and adding
// until its second operand is used up, then a restoring divide of num^2*2^30
// by den into a 31-bit quotient and an integer square root of that quotient.
// The result word is registered. The coefficient comes out as signed Q1.15
// truncated toward zero, +1 saturates to 32767; a zero denominator gives 0
// with degenerate set. Sums and flags clear once the result word is loaded,
// and the next vector may start while it waits.
module pearson_correlation_core
    import pcc_pkg::*;
#(
    parameter int MAX_ITEMS    = MAX_ITEMS_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  pair_t   pair,
    input  logic    pair_valid,
    output logic    pair_stall,
    output result_t result,
    output logic    result_valid,
    input  logic    result_stall
);

    localparam int SW  = SAMPLE_WIDTH;
    localparam int NB  = $clog2(MAX_ITEMS + 1);
    localparam int SXW = SW + NB;                 // Sx, Sy
    localparam int SQW = 2 * SW + NB - 1;         // Sxy, Sxx, Syy
    localparam int VM  = 2 * NB + 2 * SW - 2;     // magnitude bits of num, vx, vy
    localparam int OW  = VM + 1;                  // signed operand width
    localparam int DW  = 2 * VM;                  // den, num^2
    localparam int AW  = 2 * VM + 2;              // accumulator / remainder

    localparam logic [NB-1:0]    MAX_CNT  = NB'(MAX_ITEMS);
    localparam logic [UOP_W-1:0] LAST_UOP = UOP_W'(NUM_UOPS - 1);

    // Input stage
    logic                  in_v_reg;
    logic                  last_reg;
    logic signed [SW-1:0]  x_reg;
    logic signed [SW-1:0]  y_reg;

    // Running sums
    logic        [NB-1:0]  count_reg,  count_next;
    logic                  ovf_reg,    ovf_next;
    logic signed [SXW-1:0] sum_x_reg,  sum_x_next;
    logic signed [SXW-1:0] sum_y_reg,  sum_y_next;
    logic signed [SQW-1:0] sum_xy_reg, sum_xy_next;
    logic signed [SQW-1:0] sum_xx_reg, sum_xx_next;
    logic signed [SQW-1:0] sum_yy_reg, sum_yy_next;

    // Sequencer and shared unit
    state_t                state_reg,  state_next;
    logic    [UOP_W-1:0]   uop_reg,    uop_next;
    logic    [AW-1:0]      a_reg,      a_next;
    logic    [VM-1:0]      b_reg,      b_next;
    logic                  sub_reg,    sub_next;
    logic signed [AW-1:0]  acc_reg,    acc_next;
    logic signed [OW-1:0]  num_reg,    num_next;
    logic signed [OW-1:0]  vx_reg,     vx_next;
    logic signed [OW-1:0]  vy_reg,     vy_next;
    logic    [DW-1:0]      den_reg,    den_next;
    logic                  degen_reg,  degen_next;
    logic    [STEP_W-1:0]  step_reg,   step_next;
    logic    [QUO_W-1:0]   quo_reg,    quo_next;
    logic    [QUO_W-1:0]   sq_op_reg,  sq_op_next;
    logic    [QUO_W-1:0]   sq_res_reg, sq_res_next;

    // Output register
    result_t               res_reg,    res_next;
    logic                  res_v_reg,  res_v_next;

    // Datapath helpers
    logic signed [2*SW-1:0] prod_xy;
    logic signed [2*SW-1:0] prod_xx;
    logic signed [2*SW-1:0] prod_yy;
    uop_t                   uop;
    logic signed [OW-1:0]   va;
    logic signed [OW-1:0]   vb;
    logic        [VM-1:0]   va_mag;
    logic        [VM-1:0]   vb_mag;
    logic signed [AW-1:0]   addend;
    logic                   do_sub;
    logic signed [AW-1:0]   alu;
    logic                   div_ge;
    logic        [QUO_W-1:0] sq_one;
    logic        [QUO_W-1:0] sq_trial;
    logic                   sq_ge;
    logic        [Q_W-1:0]  q_mag;
    logic                   out_free;

    assign pair_stall   = (state_reg != S_ACC) || (in_v_reg && last_reg);
    assign result       = res_reg;
    assign result_valid = res_v_reg;

    // Pair products for the accumulate stage
    assign prod_xy = x_reg * y_reg;
    assign prod_xx = x_reg * x_reg;
    assign prod_yy = y_reg * y_reg;

    // Operand selection for the current multiply pass
    assign uop = uop_at(uop_reg);

    always_comb
    begin
        case (uop.src_a)
            SRC_N:   va = signed'(OW'(count_reg));
            SRC_SX:  va = OW'(sum_x_reg);
            SRC_SY:  va = OW'(sum_y_reg);
            SRC_SXY: va = OW'(sum_xy_reg);
            SRC_SXX: va = OW'(sum_xx_reg);
            SRC_SYY: va = OW'(sum_yy_reg);
            SRC_VX:  va = vx_reg;
            SRC_VY:  va = vy_reg;
            SRC_NUM: va = num_reg;
            default: va = '0;
        endcase
        case (uop.src_b)
            SRC_N:   vb = signed'(OW'(count_reg));
            SRC_SX:  vb = OW'(sum_x_reg);
            SRC_SY:  vb = OW'(sum_y_reg);
            SRC_SXY: vb = OW'(sum_xy_reg);
            SRC_SXX: vb = OW'(sum_xx_reg);
            SRC_SYY: vb = OW'(sum_yy_reg);
            SRC_VX:  vb = vx_reg;
            SRC_VY:  vb = vy_reg;
            SRC_NUM: vb = num_reg;
            default: vb = '0;
        endcase
    end

    assign va_mag = va[OW-1] ? VM'(-va) : VM'(va);
    assign vb_mag = vb[OW-1] ? VM'(-vb) : VM'(vb);

    // Shared add/subtract: shift-add products, or remainder minus den
    assign addend = (state_reg == S_DIV) ? signed'(AW'(den_reg)) : signed'(a_reg);
    assign do_sub = (state_reg == S_DIV) ? 1'b1 : sub_reg;
    assign alu    = do_sub ? (acc_reg - addend) : (acc_reg + addend);
    assign div_ge = !alu[AW-1];

    // Square root, one result bit a step
    assign sq_one   = QUO_W'(1) << {step_reg[3:0], 1'b0};
    assign sq_trial = sq_res_reg + sq_one;
    assign sq_ge    = (sq_op_reg >= sq_trial);

    assign q_mag    = sq_res_reg[Q_W-1:0];
    assign out_free = !res_v_reg || !result_stall;

    // Next state and datapath control
    always_comb
    begin
        state_next  = state_reg;
        uop_next    = uop_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        sub_next    = sub_reg;
        acc_next    = acc_reg;
        num_next    = num_reg;
        vx_next     = vx_reg;
        vy_next     = vy_reg;
        den_next    = den_reg;
        degen_next  = degen_reg;
        step_next   = step_reg;
        quo_next    = quo_reg;
        sq_op_next  = sq_op_reg;
        sq_res_next = sq_res_reg;
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        sum_x_next  = sum_x_reg;
        sum_y_next  = sum_y_reg;
        sum_xy_next = sum_xy_reg;
        sum_xx_next = sum_xx_reg;
        sum_yy_next = sum_yy_reg;
        res_next    = res_reg;
        res_v_next  = res_v_reg && result_stall;

        case (state_reg)
            S_ACC:
            begin
                if (in_v_reg)
                begin
                    if (count_reg < MAX_CNT)
                    begin
                        count_next  = count_reg + NB'(1);
                        sum_x_next  = sum_x_reg + SXW'(x_reg);
                        sum_y_next  = sum_y_reg + SXW'(y_reg);
                        sum_xy_next = sum_xy_reg + SQW'(prod_xy);
                        sum_xx_next = sum_xx_reg + SQW'(prod_xx);
                        sum_yy_next = sum_yy_reg + SQW'(prod_yy);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last_reg)
                    begin
                        uop_next   = '0;
                        state_next = S_LOAD;
                    end
                end
            end

            S_LOAD:
            begin
                a_next   = AW'(va_mag);
                b_next   = vb_mag;
                sub_next = uop.sub ^ va[OW-1] ^ vb[OW-1];
                if (uop.clr)
                begin
                    acc_next = '0;
                end
                state_next = S_MUL;
            end

            S_MUL:
            begin
                if (b_reg == '0)
                begin
                    case (uop.dst)
                        DST_NUM:  num_next = acc_reg[OW-1:0];
                        DST_VX:   vx_next  = acc_reg[OW-1:0];
                        DST_VY:   vy_next  = acc_reg[OW-1:0];
                        DST_DEN:  den_next = acc_reg[DW-1:0];
                        DST_NONE: ;
                        default:  ;
                    endcase
                    if (uop_reg == LAST_UOP)
                    begin
                        // acc now holds num^2
                        degen_next = (den_reg == '0);
                        quo_next   = '0;
                        step_next  = STEP_W'(QUO_W - 1);
                        state_next = (den_reg == '0) ? S_DONE : S_DIV;
                    end
                    else
                    begin
                        uop_next   = uop_reg + UOP_W'(1);
                        state_next = S_LOAD;
                    end
                end
                else
                begin
                    if (b_reg[0])
                    begin
                        acc_next = alu;
                    end
                    a_next = a_reg << 1;
                    b_next = b_reg >> 1;
                end
            end

            S_DIV:
            begin
                // remainder stays below 2*den
                acc_next = div_ge ? (alu <<< 1) : (acc_reg <<< 1);
                quo_next = {quo_reg[QUO_W-2:0], div_ge};
                if (step_reg == '0)
                begin
                    sq_op_next  = {quo_reg[QUO_W-2:0], div_ge};
                    sq_res_next = '0;
                    step_next   = STEP_W'(SQRT_BITS - 1);
                    state_next  = S_SQRT;
                end
                else
                begin
                    step_next = step_reg - STEP_W'(1);
                end
            end

            S_SQRT:
            begin
                if (sq_ge)
                begin
                    sq_op_next  = sq_op_reg - sq_trial;
                    sq_res_next = (sq_res_reg >> 1) + sq_one;
                end
                else
                begin
                    sq_res_next = sq_res_reg >> 1;
                end
                if (step_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    step_next = step_reg - STEP_W'(1);
                end
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    if (degen_reg)
                    begin
                        res_next.corr_q15 = '0;
                    end
                    else if (num_reg[OW-1])
                    begin
                        res_next.corr_q15 = signed'(Q_W'(0) - q_mag);
                    end
                    else
                    begin
                        res_next.corr_q15 = signed'(q_mag[Q_W-1] ? Q_POS_MAX : q_mag);
                    end
                    res_next.degenerate = degen_reg;
                    res_next.overflow   = ovf_reg;
                    res_next.pair_count = COUNT_PORT_W'(count_reg);
                    res_v_next          = 1'b1;
                    // start a fresh vector
                    count_next  = '0;
                    ovf_next    = 1'b0;
                    sum_x_next  = '0;
                    sum_y_next  = '0;
                    sum_xy_next = '0;
                    sum_xx_next = '0;
                    sum_yy_next = '0;
                    state_next  = S_ACC;
                end
            end

            default:
            begin
                state_next = S_ACC;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_ACC;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Control registers and sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg   <= 1'b0;
            res_v_reg  <= 1'b0;
            uop_reg    <= '0;
            step_reg   <= '0;
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
            degen_reg  <= 1'b0;
            sum_x_reg  <= '0;
            sum_y_reg  <= '0;
            sum_xy_reg <= '0;
            sum_xx_reg <= '0;
            sum_yy_reg <= '0;
        end
        else
        begin
            in_v_reg   <= pair_valid && !pair_stall;
            res_v_reg  <= res_v_next;
            uop_reg    <= uop_next;
            step_reg   <= step_next;
            count_reg  <= count_next;
            ovf_reg    <= ovf_next;
            degen_reg  <= degen_next;
            sum_x_reg  <= sum_x_next;
            sum_y_reg  <= sum_y_next;
            sum_xy_reg <= sum_xy_next;
            sum_xx_reg <= sum_xx_next;
            sum_yy_reg <= sum_yy_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (pair_valid && !pair_stall)
        begin
            // low SAMPLE_WIDTH bits of the port, as two's complement
            x_reg    <= signed'(SW'($unsigned(pair.sample_x)));
            y_reg    <= signed'(SW'($unsigned(pair.sample_y)));
            last_reg <= pair.last_pair;
        end
        a_reg      <= a_next;
        b_reg      <= b_next;
        sub_reg    <= sub_next;
        acc_reg    <= acc_next;
        num_reg    <= num_next;
        vx_reg     <= vx_next;
        vy_reg     <= vy_next;
        den_reg    <= den_next;
        quo_reg    <= quo_next;
        sq_op_reg  <= sq_op_next;
        sq_res_reg <= sq_res_next;
        res_reg    <= res_next;
    end

`ifndef SYNTHESIS
    // Input is held off whenever the sequencer is busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_ACC) |-> pair_stall)
        else $error("pair accepted while sequencer busy");

    // Pair count never passes the limit
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_CNT)
        else $error("pair count beyond limit");

    // Division remainder stays in [0, 2*den)
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |->
            (!acc_reg[AW-1] && ($unsigned(acc_reg) < (AW'(den_reg) << 1))))
        else $error("divider remainder out of range");

    // Variances are never negative once the divide starts
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (!vx_reg[OW-1] && !vy_reg[OW-1]))
        else $error("negative variance");

    // Degenerate result word carries a zero coefficient
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_v_reg && res_reg.degenerate) |-> (res_reg.corr_q15 == '0))
        else $error("degenerate result with nonzero coefficient");
`endif

endmodule
